// ===== sv/acc_alu_pkg.sv =====
// Shared types and codes for the 40-bit accumulator arithmetic unit.
`default_nettype none

package acc_alu_pkg;

   localparam int FIELD_BITS   = 40;
   localparam int WORD_BITS_DEF = 40;

   typedef enum logic [1:0] {
      KIND_EXEC   = 2'd0,
      KIND_WR_ACC = 2'd1,
      KIND_WR_MQ  = 2'd2
   } kind_type;

   typedef logic [7:0] opcode_type;

   localparam opcode_type OP_LOAD       = 8'd1;
   localparam opcode_type OP_LOAD_NEG   = 8'd2;
   localparam opcode_type OP_LOAD_ABS   = 8'd3;
   localparam opcode_type OP_LOAD_NABS  = 8'd4;
   localparam opcode_type OP_ADD        = 8'd5;
   localparam opcode_type OP_SUB        = 8'd6;
   localparam opcode_type OP_ADD_ABS    = 8'd7;
   localparam opcode_type OP_SUB_ABS    = 8'd8;
   localparam opcode_type OP_LOAD_MQ_M  = 8'd9;
   localparam opcode_type OP_LOAD_MQ    = 8'd10;
   localparam opcode_type OP_MUL        = 8'd11;
   localparam opcode_type OP_DIV        = 8'd12;
   localparam opcode_type OP_LSH        = 8'd20;
   localparam opcode_type OP_RSH        = 8'd21;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_BAD_OP  = 2'd1;
   localparam status_type STATUS_DIV_ZERO = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIX_MUL,
      ST_FIX_DIV,
      ST_PUSH
   } state_type;

endpackage

`default_nettype wire

// ===== sv/accumulator_alu_40bit.sv =====
// Accumulator / multiplier-quotient arithmetic unit with bit-serial multiply and divide.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   req     | in        | req_valid/req_stall | req_kind, req_opcode, req_operand
//   rsp     | out       | rsp_valid/rsp_stall | rsp_acc_value, rsp_mq_reg, rsp_status
//
// Loads, adds, shifts and direct writes update the registers, then move the result
// into the output register.
// Multiply and divide go through setup, one shift-add or restoring-subtract step per bit,
// a sign fix-up step, then the output move; a divide by zero goes straight to the output move.
// Synchronous reset clears both registers and the output valid.
// A new item is taken while the previous result still waits in the output register.
`default_nettype none

module accumulator_alu_40bit #(
   parameter int WORD_BITS = acc_alu_pkg::WORD_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [1:0]                            req_kind,
   input  wire logic [7:0]                            req_opcode,
   input  wire logic signed [acc_alu_pkg::FIELD_BITS-1:0] req_operand,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [acc_alu_pkg::FIELD_BITS-1:0]  rsp_acc_value,
   output logic signed [acc_alu_pkg::FIELD_BITS-1:0]  rsp_mq_reg,
   output logic [1:0]                                 rsp_status
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   acc_alu_pkg::state_type state_ff, state_in;

   logic [WORD_BITS-1:0]   acc_ff, acc_in;
   logic [WORD_BITS-1:0]   mq_ff, mq_in;
   logic [WORD_BITS-1:0]   opnd_ff, opnd_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   neg_q_ff, neg_q_in;
   logic                   neg_r_ff, neg_r_in;
   acc_alu_pkg::status_type status_ff, status_in;

   logic                   rsp_valid_ff;
   logic signed [acc_alu_pkg::FIELD_BITS-1:0] rsp_acc_value_ff;
   logic signed [acc_alu_pkg::FIELD_BITS-1:0] rsp_mq_reg_ff;
   acc_alu_pkg::status_type rsp_status_ff;

   logic                   accept;
   logic                   push_ok;
   logic                   div_zero;
   logic                   is_exec;

   logic [WORD_BITS-1:0]   m;
   logic                   m_neg;
   logic [WORD_BITS-1:0]   m_mag;
   logic                   acc_sign;
   logic [WORD_BITS-1:0]   acc_mag;
   logic [WORD_BITS-1:0]   mq_mag;
   logic [WORD_BITS-1:0]   half_mag;
   logic [WORD_BITS:0]     mul_sum;
   logic [WORD_BITS:0]     div_shift;
   logic [WORD_BITS:0]     div_trial;

   assign req_stall = (state_ff != acc_alu_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign push_ok   = !rsp_valid_ff || !rsp_stall;

   assign m        = WORD_BITS'($signed(req_operand));
   assign m_neg    = m[WORD_BITS-1];
   assign m_mag    = m_neg ? (~m + 1'b1) : m;
   assign acc_sign = acc_ff[WORD_BITS-1];
   assign acc_mag  = acc_sign ? (~acc_ff + 1'b1) : acc_ff;
   assign mq_mag   = mq_ff[WORD_BITS-1] ? (~mq_ff + 1'b1) : mq_ff;
   assign half_mag = acc_mag >> 1;

   assign is_exec  = (req_kind == acc_alu_pkg::KIND_EXEC);
   assign div_zero = (m == '0);

   // one shift-add step: add multiplicand when the low multiplier bit is set
   assign mul_sum   = {1'b0, acc_ff} + (mq_ff[0] ? {1'b0, opnd_ff} : '0);
   // one restoring-divide step
   assign div_shift = {acc_ff, mq_ff[WORD_BITS-1]};
   assign div_trial = div_shift - {1'b0, opnd_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acc_alu_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_exec && (req_opcode == acc_alu_pkg::OP_MUL)) begin
                  state_in = acc_alu_pkg::ST_MUL;
               end else if (is_exec && (req_opcode == acc_alu_pkg::OP_DIV) && !div_zero) begin
                  state_in = acc_alu_pkg::ST_DIV;
               end else begin
                  state_in = acc_alu_pkg::ST_PUSH;
               end
            end
         end
         acc_alu_pkg::ST_MUL: begin
            if (cnt_ff == '0) state_in = acc_alu_pkg::ST_FIX_MUL;
         end
         acc_alu_pkg::ST_DIV: begin
            if (cnt_ff == '0) state_in = acc_alu_pkg::ST_FIX_DIV;
         end
         acc_alu_pkg::ST_FIX_MUL: state_in = acc_alu_pkg::ST_PUSH;
         acc_alu_pkg::ST_FIX_DIV: state_in = acc_alu_pkg::ST_PUSH;
         acc_alu_pkg::ST_PUSH: begin
            if (push_ok) state_in = acc_alu_pkg::ST_IDLE;
         end
         default: state_in = acc_alu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in    = acc_ff;
      mq_in     = mq_ff;
      opnd_in   = opnd_ff;
      cnt_in    = cnt_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      status_in = status_ff;
      case (state_ff)
         acc_alu_pkg::ST_IDLE: begin
            if (accept) begin
               status_in = acc_alu_pkg::STATUS_OK;
               cnt_in    = CNT_BITS'(WORD_BITS - 1);
               case (acc_alu_pkg::kind_type'(req_kind))
                  acc_alu_pkg::KIND_WR_ACC: acc_in = m;
                  acc_alu_pkg::KIND_WR_MQ:  mq_in  = m;
                  acc_alu_pkg::KIND_EXEC: begin
                     case (req_opcode)
                        acc_alu_pkg::OP_LOAD:      acc_in = m;
                        acc_alu_pkg::OP_LOAD_NEG:  acc_in = ~m + 1'b1;
                        acc_alu_pkg::OP_LOAD_ABS:  acc_in = m_mag;
                        acc_alu_pkg::OP_LOAD_NABS: acc_in = ~m_mag + 1'b1;
                        acc_alu_pkg::OP_ADD:       acc_in = acc_ff + m;
                        acc_alu_pkg::OP_SUB:       acc_in = acc_ff - m;
                        acc_alu_pkg::OP_ADD_ABS:   acc_in = acc_ff + m_mag;
                        acc_alu_pkg::OP_SUB_ABS:   acc_in = acc_ff - m_mag;
                        acc_alu_pkg::OP_LOAD_MQ_M: mq_in  = m;
                        acc_alu_pkg::OP_LOAD_MQ:   acc_in = mq_ff;
                        acc_alu_pkg::OP_MUL: begin
                           opnd_in  = m_mag;
                           acc_in   = '0;
                           mq_in    = mq_mag;
                           neg_q_in = m_neg ^ mq_ff[WORD_BITS-1];
                        end
                        acc_alu_pkg::OP_DIV: begin
                           if (div_zero) begin
                              status_in = acc_alu_pkg::STATUS_DIV_ZERO;
                           end else begin
                              opnd_in  = m_mag;
                              acc_in   = '0;
                              mq_in    = acc_mag;
                              neg_q_in = acc_sign ^ m_neg;
                              neg_r_in = acc_sign;
                           end
                        end
                        acc_alu_pkg::OP_LSH: acc_in = {acc_ff[WORD_BITS-2:0], 1'b0};
                        acc_alu_pkg::OP_RSH: acc_in = acc_sign ? (~half_mag + 1'b1) : half_mag;
                        default: status_in = acc_alu_pkg::STATUS_BAD_OP;
                     endcase
                  end
                  default: status_in = acc_alu_pkg::STATUS_BAD_OP;
               endcase
            end
         end
         acc_alu_pkg::ST_MUL: begin
            // shift the partial product right one bit into the low word
            acc_in = mul_sum[WORD_BITS:1];
            mq_in  = {mul_sum[0], mq_ff[WORD_BITS-1:1]};
            cnt_in = cnt_ff - 1'b1;
         end
         acc_alu_pkg::ST_DIV: begin
            if (!div_trial[WORD_BITS]) begin
               acc_in = div_trial[WORD_BITS-1:0];
               mq_in  = {mq_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               acc_in = div_shift[WORD_BITS-1:0];
               mq_in  = {mq_ff[WORD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         acc_alu_pkg::ST_FIX_MUL: begin
            // negate the double-length product; the carry passes to the high word
            if (neg_q_ff) begin
               mq_in  = ~mq_ff + 1'b1;
               acc_in = ~acc_ff + ((mq_ff == '0) ? WORD_BITS'(1) : '0);
            end
         end
         acc_alu_pkg::ST_FIX_DIV: begin
            if (neg_q_ff) mq_in  = ~mq_ff + 1'b1;
            if (neg_r_ff) acc_in = ~acc_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acc_alu_pkg::ST_IDLE;
         acc_ff       <= '0;
         mq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         mq_ff    <= mq_in;
         if ((state_ff == acc_alu_pkg::ST_PUSH) && push_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff   <= opnd_in;
      cnt_ff    <= cnt_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      status_ff <= status_in;
      if ((state_ff == acc_alu_pkg::ST_PUSH) && push_ok) begin
         rsp_acc_value_ff <= acc_alu_pkg::FIELD_BITS'($signed(acc_ff));
         rsp_mq_reg_ff    <= acc_alu_pkg::FIELD_BITS'($signed(mq_ff));
         rsp_status_ff    <= status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_acc_value = rsp_acc_value_ff;
   assign rsp_mq_reg    = rsp_mq_reg_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire
